FILE: src/assert_macros.svh
// assertion macros used by the checker file
// no dependencies; clk and rst_n must exist where the macros are used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only out of reset
`define MTENC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define MTENC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/mtenc_pkg.sv
// widths, constants and helpers of the multi-turn encoder angle tracker
// no dependencies
package mtenc_pkg;

  localparam int ANGLE_BITS = 12;
  localparam int TURN_BITS  = 16;

  localparam int PP_W      = 7;
  localparam int GAIN_W    = 16;
  localparam int GAIN_FRAC = 16;
  localparam int ELEC_W    = ANGLE_BITS;
  localparam int FULL_W    = 28;
  localparam int SPEED_W   = 24;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = GAIN_W;

  localparam logic [CFG_IDX_W-1:0] CFG_POLE_PAIRS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_DIR_REV    = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_RPM_GAIN   = CFG_IDX_W'(2);

  localparam int ANGLE_SPAN = 1 << ANGLE_BITS;
  localparam int WRAP_LIMIT = (4 * ANGLE_SPAN) / 5;

  // angle difference, one bit wider than an angle
  localparam logic signed [ANGLE_BITS:0] WRAP_HI = (ANGLE_BITS+1)'(WRAP_LIMIT);
  localparam logic signed [ANGLE_BITS:0] WRAP_LO = (ANGLE_BITS+1)'(-WRAP_LIMIT);

  localparam logic signed [TURN_BITS-1:0] TURN_MAX = {1'b0, {(TURN_BITS-1){1'b1}}};
  localparam logic signed [TURN_BITS-1:0] TURN_MIN =
    {1'b1, {(TURN_BITS-2){1'b0}}, 1'b1};

  localparam int FULL_CALC_W = TURN_BITS + ANGLE_BITS + 1;
  localparam logic signed [FULL_CALC_W-1:0] FULL_HI = FULL_CALC_W'(134217727);
  localparam logic signed [FULL_CALC_W-1:0] FULL_LO = FULL_CALC_W'(-134217727);

  localparam int DELTA_W    = TURN_BITS + ANGLE_BITS + 2;
  localparam int PROD_W     = DELTA_W + GAIN_W + 1;
  localparam int SPD_WIDE_W = PROD_W - GAIN_FRAC;

  localparam logic signed [PROD_W-1:0] RND_HALF =
    {{(PROD_W-GAIN_FRAC){1'b0}}, 1'b1, {(GAIN_FRAC-1){1'b0}}};
  localparam logic signed [SPD_WIDE_W-1:0] SPD_HI = SPD_WIDE_W'(8388607);
  localparam logic signed [SPD_WIDE_W-1:0] SPD_LO = SPD_WIDE_W'(-8388608);

  // mechanical angle to electrical angle, one electrical turn wide
  function automatic logic [ELEC_W-1:0] elec_of(input logic [ANGLE_BITS-1:0] ang,
                                                input logic [PP_W-1:0] pp,
                                                input logic rev);
    logic [ANGLE_BITS+PP_W-1:0] prod;
    logic [ELEC_W-1:0]          lo;
    prod = ang * pp;
    lo   = prod[ELEC_W-1:0];
    return rev ? ELEC_W'(-lo) : lo;
  endfunction

endpackage

FILE: src/mtenc_in_if.sv
// input channel of the angle tracker: one angle sample per item
// depends on mtenc_pkg
interface mtenc_in_if import mtenc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [ANGLE_BITS-1:0] raw_angle;
  logic                  align;
  logic                  velocity_strobe;

  modport source (output valid, raw_angle, align, velocity_strobe, input ready);
  modport sink   (input valid, raw_angle, align, velocity_strobe, output ready);
endinterface

FILE: src/mtenc_out_if.sv
// result channel of the angle tracker: one result item per sample
// depends on mtenc_pkg
interface mtenc_out_if import mtenc_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [ELEC_W-1:0]         electrical_angle;
  logic signed [FULL_W-1:0]  full_angle;
  logic signed [SPEED_W-1:0] speed_rpm;
  logic                      speed_valid;

  modport source (output valid, electrical_angle, full_angle, speed_rpm, speed_valid,
                  input ready);
  modport sink   (input valid, electrical_angle, full_angle, speed_rpm, speed_valid,
                  output ready);
endinterface

FILE: src/multiturn_encoder_angle_tracker_unit.sv
// multi-turn angle tracker top level: turn counting, zero capture, speed
// depends on mtenc_pkg, mtenc_in_if, mtenc_out_if
//
// usage:
//   in_  : angle samples (raw_angle, align, velocity_strobe), valid/ready
//   out_ : one result per sample (electrical_angle, full_angle, speed_rpm,
//          speed_valid), valid/ready
//   cfg_ : write-only registers (pole pairs, direction, rpm gain), written
//          while no item is in flight
// a sample enters an input register, updates the tracker state on its way
// into the second stage, the speed product is formed in the third and is
// rounded and clamped into the output register, which raises out_.valid
// throughput is one item per cycle while out_.ready holds; the turn
// counter update (wrap compare and saturating step) is combinational,
// so samples may follow back to back
// each stage holds while the one after it is full, so a stalled receiver
// fills the four stages before in_.ready drops
// reset clears the tracker state, the snapshots and all stage valid bits,
// and loads pole_pairs 1, direction forward, rpm_gain 1
module multiturn_encoder_angle_tracker_unit import mtenc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  mtenc_in_if.sink              in_,
  mtenc_out_if.source           out_,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // configuration
  logic [PP_W-1:0]   pole_pairs_r;
  logic              dir_rev_r;
  logic [GAIN_W-1:0] rpm_gain_r;

  // tracker state
  logic signed [TURN_BITS-1:0] turn_count_r, turn_count_nxt;
  logic [ANGLE_BITS-1:0]       last_angle_r, last_angle_nxt;
  logic [ANGLE_BITS-1:0]       zero_raw_r, zero_raw_nxt;
  logic [ELEC_W-1:0]           zero_elec_r, zero_elec_nxt;
  logic signed [TURN_BITS-1:0] snap_turn_r;
  logic [ANGLE_BITS-1:0]       snap_angle_r;

  // stage 1: input register
  logic                  s1_valid_r;
  logic [ANGLE_BITS-1:0] s1_raw_r;
  logic                  s1_align_r;
  logic                  s1_strobe_r;

  // stage 2: tracker outputs and speed delta
  logic                       s2_valid_r;
  logic signed [DELTA_W-1:0]  s2_delta_r, s2_delta_nxt;
  logic [ELEC_W-1:0]          s2_elec_r, s2_elec_nxt;
  logic signed [FULL_W-1:0]   s2_full_r, s2_full_nxt;
  logic                       s2_strobe_r;

  // stage 3: speed product
  logic                      s3_valid_r;
  logic signed [PROD_W-1:0]  s3_prod_r, s3_prod_nxt;
  logic [ELEC_W-1:0]         s3_elec_r;
  logic signed [FULL_W-1:0]  s3_full_r;
  logic                      s3_strobe_r;

  // output register
  logic                      out_valid_r;
  logic [ELEC_W-1:0]         out_elec_r;
  logic signed [FULL_W-1:0]  out_full_r;
  logic signed [SPEED_W-1:0] out_speed_r, out_speed_nxt;
  logic                      out_spdv_r;

  logic out_free, s3_free, s2_free, s1_free;
  logic s1_adv;

  logic signed [ANGLE_BITS:0]  ang_diff;
  logic signed [TURN_BITS:0]   turn_diff;
  logic signed [ANGLE_BITS:0]  snap_ang_diff;
  logic signed [FULL_CALC_W-1:0] full_sum;
  logic signed [PROD_W-1:0]     rnd_sum;
  logic signed [SPD_WIDE_W-1:0] spd_wide;

  assign out_free = !out_valid_r || out_.ready;
  assign s3_free  = !s3_valid_r || out_free;
  assign s2_free  = !s2_valid_r || s3_free;
  assign s1_free  = !s1_valid_r || s2_free;
  assign s1_adv   = s1_valid_r && s2_free;

  assign in_.ready = s1_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pole_pairs_r <= PP_W'(1);
      dir_rev_r    <= 1'b0;
      rpm_gain_r   <= GAIN_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_POLE_PAIRS: pole_pairs_r <= cfg_data[PP_W-1:0];
        CFG_DIR_REV:    dir_rev_r    <= cfg_data[0];
        CFG_RPM_GAIN:   rpm_gain_r   <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // tracker update for the item leaving stage 1
  always_comb begin
    ang_diff       = $signed({1'b0, s1_raw_r}) - $signed({1'b0, last_angle_r});
    turn_count_nxt = turn_count_r;
    last_angle_nxt = last_angle_r;
    zero_raw_nxt   = zero_raw_r;
    zero_elec_nxt  = zero_elec_r;
    if (s1_align_r) begin
      zero_raw_nxt  = s1_raw_r;
      zero_elec_nxt = elec_of(s1_raw_r, pole_pairs_r, dir_rev_r);
    end else begin
      // forward wrap reads as a big negative jump, backward as a big positive
      if (ang_diff > WRAP_HI) begin
        if (turn_count_r != TURN_MIN) turn_count_nxt = turn_count_r - TURN_BITS'(1);
      end else if (ang_diff < WRAP_LO) begin
        if (turn_count_r != TURN_MAX) turn_count_nxt = turn_count_r + TURN_BITS'(1);
      end
      last_angle_nxt = s1_raw_r;
    end
  end

  always_comb begin
    s2_elec_nxt = elec_of(last_angle_nxt, pole_pairs_r, dir_rev_r) - zero_elec_nxt;

    full_sum = FULL_CALC_W'($signed({turn_count_nxt, {ANGLE_BITS{1'b0}}}))
             + FULL_CALC_W'($signed({1'b0, last_angle_nxt}) - $signed({1'b0, zero_raw_nxt}));
    if (full_sum > FULL_HI)      s2_full_nxt = FULL_HI[FULL_W-1:0];
    else if (full_sum < FULL_LO) s2_full_nxt = FULL_LO[FULL_W-1:0];
    else                         s2_full_nxt = full_sum[FULL_W-1:0];

    turn_diff     = (TURN_BITS+1)'(turn_count_nxt) - (TURN_BITS+1)'(snap_turn_r);
    snap_ang_diff = $signed({1'b0, last_angle_nxt}) - $signed({1'b0, snap_angle_r});
    s2_delta_nxt  = DELTA_W'($signed({turn_diff, {ANGLE_BITS{1'b0}}}))
                  + DELTA_W'(snap_ang_diff);
  end

  assign s3_prod_nxt = s2_delta_r * $signed({1'b0, rpm_gain_r});

  // round to nearest, ties up, then clamp to the speed range; zero without a strobe
  always_comb begin
    rnd_sum  = s3_prod_r + RND_HALF;
    spd_wide = $signed(rnd_sum[PROD_W-1:GAIN_FRAC]);
    if (!s3_strobe_r)          out_speed_nxt = '0;
    else if (spd_wide > SPD_HI) out_speed_nxt = SPD_HI[SPEED_W-1:0];
    else if (spd_wide < SPD_LO) out_speed_nxt = SPD_LO[SPEED_W-1:0];
    else                        out_speed_nxt = spd_wide[SPEED_W-1:0];
  end

  // state and stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      turn_count_r <= '0;
      last_angle_r <= '0;
      zero_raw_r   <= '0;
      zero_elec_r  <= '0;
      snap_turn_r  <= '0;
      snap_angle_r <= '0;
      s1_valid_r   <= 1'b0;
      s2_valid_r   <= 1'b0;
      s3_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (s1_adv) begin
        turn_count_r <= turn_count_nxt;
        last_angle_r <= last_angle_nxt;
        zero_raw_r   <= zero_raw_nxt;
        zero_elec_r  <= zero_elec_nxt;
        if (s1_strobe_r) begin
          snap_turn_r  <= turn_count_nxt;
          snap_angle_r <= last_angle_nxt;
        end
      end
      if (s1_free)  s1_valid_r  <= in_.valid;
      if (s2_free)  s2_valid_r  <= s1_valid_r;
      if (s3_free)  s3_valid_r  <= s2_valid_r;
      if (out_free) out_valid_r <= s3_valid_r;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (s1_free && in_.valid) begin
      s1_raw_r    <= in_.raw_angle;
      s1_align_r  <= in_.align;
      s1_strobe_r <= in_.velocity_strobe;
    end
    if (s1_adv) begin
      s2_delta_r  <= s2_delta_nxt;
      s2_elec_r   <= s2_elec_nxt;
      s2_full_r   <= s2_full_nxt;
      s2_strobe_r <= s1_strobe_r;
    end
    if (s2_valid_r && s3_free) begin
      s3_prod_r   <= s3_prod_nxt;
      s3_elec_r   <= s2_elec_r;
      s3_full_r   <= s2_full_r;
      s3_strobe_r <= s2_strobe_r;
    end
    if (s3_valid_r && out_free) begin
      out_elec_r  <= s3_elec_r;
      out_full_r  <= s3_full_r;
      out_speed_r <= out_speed_nxt;
      out_spdv_r  <= s3_strobe_r;
    end
  end

  assign out_.valid            = out_valid_r;
  assign out_.electrical_angle = out_elec_r;
  assign out_.full_angle       = out_full_r;
  assign out_.speed_rpm        = out_speed_r;
  assign out_.speed_valid      = out_spdv_r;

endmodule

FILE: src/mtenc_checker.sv
// port-level checks for the multi-turn angle tracker, bound to the top level
// depends on mtenc_pkg and assert_macros.svh
`include "assert_macros.svh"

module mtenc_checker import mtenc_pkg::*; (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [ELEC_W-1:0]         out_electrical_angle,
  input logic signed [FULL_W-1:0]  out_full_angle,
  input logic signed [SPEED_W-1:0] out_speed_rpm,
  input logic                      out_speed_valid
);

  `MTENC_ASSERT_ALWAYS(a_reset_empties, !rst_n |=> !out_valid, "result valid right after reset")

  // an empty output register means every stage can move
  `MTENC_ASSERT(a_empty_takes_input, !out_valid |-> in_ready, "input blocked with output empty")

  `MTENC_ASSERT(a_speed_zero_unstrobed, (out_valid && !out_speed_valid) |-> (out_speed_rpm == '0), "speed nonzero without strobe")

  `MTENC_ASSERT(a_full_in_range, out_valid |-> (out_full_angle[FULL_W-1] == 1'b0 || out_full_angle[FULL_W-2:0] != '0), "full angle at most negative code")

  `MTENC_ASSERT(a_stall_holds, (out_valid && !out_ready) |=> (out_valid && $stable(out_electrical_angle) && $stable(out_full_angle) && $stable(out_speed_rpm) && $stable(out_speed_valid)), "stalled result changed")

endmodule

bind multiturn_encoder_angle_tracker_unit mtenc_checker u_mtenc_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .in_ready             (in_.ready),
  .out_valid            (out_.valid),
  .out_ready            (out_.ready),
  .out_electrical_angle (out_.electrical_angle),
  .out_full_angle       (out_.full_angle),
  .out_speed_rpm        (out_.speed_rpm),
  .out_speed_valid      (out_.speed_valid)
);
